// File: sv/phm_pkg.sv
// shared constants and control/status types for the peak hold meter
package phm_pkg;

  localparam int CH_W       = 4;
  localparam int PEAK_W     = 16;
  localparam int STEP_W     = 4;
  localparam int BOTTOM_W   = 14;
  localparam int DECAY_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam int STATUS_W   = 8;
  localparam int DATA_W     = 7;
  localparam int POS_W      = 3;
  localparam int DVD_W      = 18;
  localparam int DIV_CNT_W  = 5;

  localparam logic [STATUS_W-1:0] STATUS_STRIP  = 8'hD0;
  localparam logic [STATUS_W-1:0] STATUS_MASTER = 8'hD1;

  localparam logic [STEP_W-1:0] TOP_STEP  = 4'd12;
  localparam logic [STEP_W-1:0] ZERO_STEP = 4'd0;
  localparam logic [STEP_W-1:0] ONE_STEP  = 4'd1;
  localparam logic [DVD_W-1:0]  QUOT_CLAMP = 18'd11;

  localparam logic signed [PEAK_W-1:0] LEVEL_FLOOR = 16'sh8000;

  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DEPTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SPAN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_ENABLE = 2'd3;

  localparam logic [BOTTOM_W-1:0] FLOOR_DEPTH_RST = 14'd960;
  localparam logic [BOTTOM_W-1:0] SCALE_SPAN_RST  = 14'd960;
  localparam logic [DECAY_W-1:0]  DECAY_STEP_RST  = 12'd8;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST_CNT = 5'(DVD_W - 1);

  typedef struct packed {
    logic accept;
    logic update;
    logic classify;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic special;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

// File: sv/phm_if.sv
// valid/ready channels for meter samples and meter messages
interface phm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [phm_pkg::CH_W-1:0]             channel;
  logic signed [phm_pkg::PEAK_W-1:0]    peak_db;
  logic                                 active;

  modport source (output valid, output channel, output peak_db, output active, input ready);
  modport sink   (input valid, input channel, input peak_db, input active, output ready);
endinterface

interface phm_out_if;
  logic                            valid;
  logic                            ready;
  logic [phm_pkg::STATUS_W-1:0]    status_byte;
  logic [phm_pkg::DATA_W-1:0]      data_byte;

  modport source (output valid, output status_byte, output data_byte, input ready);
  modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

// File: sv/phm_ctrl.sv
// controller state machine sequencing update, classify, divide and emit
module phm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  phm_pkg::sts_t sts,
  output phm_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_UPDATE   = 5'b00010,
    ST_CLASSIFY = 5'b00100,
    ST_DIVIDE   = 5'b01000,
    ST_EMIT     = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid && !sts.drop) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd.classify = 1'b1;
        state_next   = sts.special ? ST_EMIT : ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: sv/phm_dp.sv
// datapath: config registers, held levels, decay, step divider, output register
module phm_dp #(
  parameter int NUM_METERS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [phm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [phm_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [phm_pkg::CH_W-1:0]            in_channel,
  input  logic signed [phm_pkg::PEAK_W-1:0]   in_peak_db,
  input  logic                                in_active,
  input  phm_pkg::cmd_t                       cmd,
  output phm_pkg::sts_t                       sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [phm_pkg::STATUS_W-1:0]        out_status_byte,
  output logic [phm_pkg::DATA_W-1:0]          out_data_byte
);

  localparam int IDX_W = (NUM_METERS > 1) ? $clog2(NUM_METERS) : 1;
  localparam logic [phm_pkg::CH_W:0] NUM_M       = (phm_pkg::CH_W + 1)'(NUM_METERS);
  localparam logic [phm_pkg::CH_W:0] MASTER_BASE = (phm_pkg::CH_W + 1)'(NUM_METERS - 2);

  // configuration
  logic [phm_pkg::BOTTOM_W-1:0] floor_depth;
  logic [phm_pkg::BOTTOM_W-1:0] scale_span;
  logic [phm_pkg::DECAY_W-1:0]  decay_step;
  logic                         master_enable;

  // item registers
  logic [phm_pkg::CH_W-1:0]          channel_r;
  logic signed [phm_pkg::PEAK_W-1:0] peak_r;
  logic signed [phm_pkg::PEAK_W-1:0] held [NUM_METERS];
  logic signed [phm_pkg::PEAK_W-1:0] level_r;
  logic [phm_pkg::STEP_W-1:0]        step_r;
  logic                              use_div_r;
  logic                              neg_r;
  logic [phm_pkg::BOTTOM_W-1:0]      q_r;
  logic [phm_pkg::BOTTOM_W-1:0]      rem;
  logic [phm_pkg::DVD_W-1:0]         dvd;
  logic [phm_pkg::DIV_CNT_W-1:0]     div_cnt;

  // input screening
  logic in_master;
  assign in_master = {1'b0, in_channel} >= MASTER_BASE;
  assign sts.drop  = ({1'b0, in_channel} >= NUM_M) ||
                     (in_master ? !master_enable : !in_active);

  // held level update
  logic signed [phm_pkg::PEAK_W-1:0] held_cur;
  logic signed [phm_pkg::PEAK_W:0]   decay_thresh;
  logic signed [phm_pkg::PEAK_W+1:0] dec;
  logic signed [phm_pkg::PEAK_W+1:0] floor_ext;
  logic signed [phm_pkg::PEAK_W-1:0] dec_sat;
  logic signed [phm_pkg::PEAK_W-1:0] decayed;
  logic signed [phm_pkg::PEAK_W-1:0] held_new;

  always_comb begin
    held_cur     = held[channel_r[IDX_W-1:0]];
    decay_thresh = -$signed({2'b00, floor_depth, 1'b0});
    dec          = $signed({{2{held_cur[phm_pkg::PEAK_W-1]}}, held_cur}) -
                   $signed({5'b00000, decay_step, 1'b0});
    floor_ext    = $signed({{2{phm_pkg::LEVEL_FLOOR[phm_pkg::PEAK_W-1]}},
                            phm_pkg::LEVEL_FLOOR});
    dec_sat      = (dec < floor_ext) ? phm_pkg::LEVEL_FLOOR : dec[phm_pkg::PEAK_W-1:0];
    decayed      = ($signed({held_cur[phm_pkg::PEAK_W-1], held_cur}) > decay_thresh) ?
                   dec_sat : held_cur;
    held_new     = (peak_r > decayed) ? peak_r : decayed;
  end

  // level classification and dividend
  logic                              lvl_ge0;
  logic                              at_floor;
  logic [phm_pkg::BOTTOM_W-1:0]      q_eff;
  logic signed [phm_pkg::PEAK_W:0]   num;
  logic signed [20:0]                num_x;
  logic signed [20:0]                num11;
  logic [20:0]                       mag;

  always_comb begin
    lvl_ge0  = !level_r[phm_pkg::PEAK_W-1];
    at_floor = $signed({level_r[phm_pkg::PEAK_W-1], level_r}) <=
               -$signed({3'b000, floor_depth});
    q_eff    = (scale_span == '0) ? phm_pkg::BOTTOM_W'(1) : scale_span;
    num      = $signed({level_r[phm_pkg::PEAK_W-1], level_r}) + $signed({3'b000, q_eff});
    num_x    = 21'(num);
    num11    = (num_x <<< 3) + (num_x <<< 1) + num_x;
    mag      = num11[20] ? 21'(-num11) : num11;
  end
  assign sts.special = lvl_ge0 || at_floor;

  // restoring divider step
  logic [phm_pkg::BOTTOM_W:0]   trial;
  logic [phm_pkg::BOTTOM_W+1:0] diff;
  logic                         fits;
  assign trial = {rem, dvd[phm_pkg::DVD_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, q_r};
  assign fits  = !diff[phm_pkg::BOTTOM_W+1];
  assign sts.div_last = (div_cnt == '0);

  // final step and message fields
  logic [phm_pkg::STEP_W-1:0] div_step_val;
  logic [phm_pkg::STEP_W-1:0] step_fin;
  logic                       is_master;
  logic [phm_pkg::CH_W:0]     master_pos;
  logic [phm_pkg::POS_W-1:0]  pos;

  always_comb begin
    if (neg_r) begin
      div_step_val = (dvd == '0) ? phm_pkg::ONE_STEP : phm_pkg::ZERO_STEP;
    end else begin
      div_step_val = (dvd >= phm_pkg::QUOT_CLAMP) ? phm_pkg::TOP_STEP :
                     (dvd[phm_pkg::STEP_W-1:0] + phm_pkg::ONE_STEP);
    end
    step_fin   = use_div_r ? div_step_val : step_r;
    is_master  = {1'b0, channel_r} >= MASTER_BASE;
    master_pos = {1'b0, channel_r} - MASTER_BASE;
    pos        = is_master ? master_pos[phm_pkg::POS_W-1:0] : channel_r[phm_pkg::POS_W-1:0];
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_depth   <= phm_pkg::FLOOR_DEPTH_RST;
      scale_span    <= phm_pkg::SCALE_SPAN_RST;
      decay_step    <= phm_pkg::DECAY_STEP_RST;
      master_enable <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        phm_pkg::REG_FLOOR_DEPTH:   floor_depth   <= cfg_data[phm_pkg::BOTTOM_W-1:0];
        phm_pkg::REG_SCALE_SPAN:    scale_span    <= cfg_data[phm_pkg::BOTTOM_W-1:0];
        phm_pkg::REG_DECAY_STEP:    decay_step    <= cfg_data[phm_pkg::DECAY_W-1:0];
        phm_pkg::REG_MASTER_ENABLE: master_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_METERS; i++) begin
        held[i] <= phm_pkg::LEVEL_FLOOR;
      end
    end else if (cmd.update) begin
      held[channel_r[IDX_W-1:0]] <= held_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      channel_r <= in_channel;
      peak_r    <= in_peak_db;
    end
    if (cmd.update) begin
      level_r <= held_new;
    end
    if (cmd.classify) begin
      step_r    <= lvl_ge0 ? phm_pkg::TOP_STEP : phm_pkg::ZERO_STEP;
      use_div_r <= !sts.special;
      neg_r     <= num11[20];
      q_r       <= q_eff;
      rem       <= '0;
      dvd       <= mag[phm_pkg::DVD_W-1:0];
      div_cnt   <= phm_pkg::DIV_LAST_CNT;
    end else if (cmd.div_step) begin
      rem     <= fits ? diff[phm_pkg::BOTTOM_W-1:0] : trial[phm_pkg::BOTTOM_W-1:0];
      dvd     <= {dvd[phm_pkg::DVD_W-2:0], fits};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_byte <= is_master ? phm_pkg::STATUS_MASTER : phm_pkg::STATUS_STRIP;
      out_data_byte   <= {pos, step_fin};
    end
  end

endmodule

// File: sv/peak_hold_meter_led_driver.sv
// top level of the peak hold level meter and led message driver
// Takes one sample beat (channel, peak in 1/16 dB, active flag) at a time while the
// controller is idle. A beat that is dropped (channel out of range, inactive strip, or a
// master channel with master_enable clear) is accepted but changes nothing. Any other
// beat decays and updates that channel's held level and produces one two-byte message;
// when the level is at or above 0 dB or at or below the floor the step is set directly,
// otherwise the 18-iteration restoring divider scales the level to a 0..12 step. A
// finished message sits in an output register, so a new sample beat is taken while it
// waits; the controller only holds in its emit step if the previous message is still
// untaken. Configuration writes are taken every cycle.
module peak_hold_meter_led_driver #(
  parameter int NUM_METERS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  phm_in_if.sink                          in_ch,
  phm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [phm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [phm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  phm_pkg::cmd_t cmd;
  phm_pkg::sts_t sts;

  phm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  phm_dp #(
    .NUM_METERS (NUM_METERS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_channel      (in_ch.channel),
    .in_peak_db      (in_ch.peak_db),
    .in_active       (in_ch.active),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status_byte (out_ch.status_byte),
    .out_data_byte   (out_ch.data_byte)
  );

endmodule

// File: sv/phm_checker.sv
// port-level checks on the meter message channel, bound to the top level
module phm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [phm_pkg::STATUS_W-1:0]   status_byte,
  input logic [phm_pkg::DATA_W-1:0]     data_byte
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status_byte) && $stable(data_byte))
    else $error("stalled output beat changed");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status_byte == phm_pkg::STATUS_STRIP ||
                  status_byte == phm_pkg::STATUS_MASTER)
    else $error("bad status byte");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> data_byte[phm_pkg::STEP_W-1:0] <= phm_pkg::TOP_STEP)
    else $error("step above top");

  // master meters sit at positions 0 and 1
  a_master_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_byte == phm_pkg::STATUS_MASTER |-> data_byte[6:5] == 2'b00)
    else $error("master position out of range");

endmodule

bind peak_hold_meter_led_driver phm_checker u_phm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status_byte (out_ch.status_byte),
  .data_byte   (out_ch.data_byte)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// testbench for the peak hold meter: directed and random beats checked against a predictor
module tb_top;

  localparam int NUM_METERS   = 10;
  localparam int MASTER_BASE  = NUM_METERS - 2;
  localparam int STEP_SPAN    = 11;
  localparam int MAX_STEP     = int'(phm_pkg::TOP_STEP);
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [phm_pkg::STATUS_W-1:0] status;
    logic [phm_pkg::DATA_W-1:0]   data;
  } meter_msg_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [phm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [phm_pkg::CFG_DATA_W-1:0] cfg_data;

  phm_in_if  in_ch ();
  phm_out_if out_ch ();

  peak_hold_meter_led_driver #(
    .NUM_METERS(NUM_METERS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // predictor copy of the registers and held levels
  logic [phm_pkg::BOTTOM_W-1:0]      bottom_cfg;
  logic [phm_pkg::BOTTOM_W-1:0]      scale_cfg;
  logic [phm_pkg::DECAY_W-1:0]       decay_cfg;
  logic                              master_cfg;
  logic signed [phm_pkg::PEAK_W-1:0] held_lvl [NUM_METERS];

  meter_msg_t pending_msgs [$];

  int errors = 0;
  int msgs_checked = 0;
  int samples_sent = 0;
  int samples_dropped = 0;
  int msgs_predicted = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_total = 0;
  int hold_seen = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int expv);
    $display("ERROR %s: got 0x%0h expected 0x%0h at %0t ns", what, got, expv, $time);
    errors++;
  endtask

  function automatic bit predict_meter(input logic [phm_pkg::CH_W-1:0] ch,
                                       input logic signed [phm_pkg::PEAK_W-1:0] pk,
                                       input logic act, output meter_msg_t msg);
    int lvl;
    int q;
    int step;
    int pos;
    logic [phm_pkg::STATUS_W-1:0] status;
    msg = '0;
    if (ch >= NUM_METERS) return 1'b0;
    if (ch >= MASTER_BASE) begin
      if (!master_cfg) return 1'b0;
      pos = ch - MASTER_BASE;
      status = phm_pkg::STATUS_MASTER;
    end else begin
      if (!act) return 1'b0;
      pos = ch;
      status = phm_pkg::STATUS_STRIP;
    end
    lvl = held_lvl[ch];
    if (lvl > -2 * int'(bottom_cfg)) begin
      lvl = lvl - 2 * int'(decay_cfg);
      if (lvl < int'(phm_pkg::LEVEL_FLOOR)) lvl = int'(phm_pkg::LEVEL_FLOOR);
    end
    if (int'(pk) > lvl) lvl = int'(pk);
    held_lvl[ch] = lvl[phm_pkg::PEAK_W-1:0];
    q = (scale_cfg == '0) ? 1 : int'(scale_cfg);
    if (lvl >= 0) begin
      step = MAX_STEP;
    end else if (lvl <= -int'(bottom_cfg)) begin
      step = int'(phm_pkg::ZERO_STEP);
    end else begin
      step = ((lvl + q) * STEP_SPAN) / q + int'(phm_pkg::ONE_STEP);
      if (step > MAX_STEP) step = MAX_STEP;
      if (step < 0) step = int'(phm_pkg::ZERO_STEP);
    end
    msg.status = status;
    msg.data = phm_pkg::DATA_W'((pos << 4) | step);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : beat_monitor
    meter_msg_t got_msg;
    meter_msg_t expected_msg;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got_msg.status = out_ch.status_byte;
        got_msg.data = out_ch.data_byte;
        if (pending_msgs.size() == 0) begin
          report_mismatch("message with none expected", int'(got_msg), 0);
        end else begin
          expected_msg = pending_msgs.pop_front();
          if (got_msg.status !== expected_msg.status)
            report_mismatch("status_byte", got_msg.status, expected_msg.status);
          if (got_msg.data !== expected_msg.data)
            report_mismatch("data_byte", got_msg.data, expected_msg.data);
          msgs_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        samples_sent++;
        if (predict_meter(in_ch.channel, in_ch.peak_db, in_ch.active, expected_msg)) begin
          pending_msgs.push_back(expected_msg);
          msgs_predicted++;
        end else begin
          samples_dropped++;
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d messages pending",
                 STALL_LIMIT, pending_msgs.size());
        $display("** peak_hold_meter_led_driver: FAILED **");
        $finish;
      end
    end
  end

  // receiver: long hold-off when requested, else random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen < hold_total) begin
        out_ch.ready <= 1'b0;
        hold_seen++;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_sample(input int ch, input int pk, input bit act);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.channel <= ch[phm_pkg::CH_W-1:0];
    in_ch.peak_db <= pk[phm_pkg::PEAK_W-1:0];
    in_ch.active <= act;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int bottom, input int scale, input int decay, input bit master);
    logic [phm_pkg::CFG_IDX_W-1:0] idx [4];
    int val [4];
    idx = '{phm_pkg::REG_FLOOR_DEPTH, phm_pkg::REG_SCALE_SPAN, phm_pkg::REG_DECAY_STEP,
            phm_pkg::REG_MASTER_ENABLE};
    val = '{bottom, scale, decay, int'(master)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i][phm_pkg::CFG_DATA_W-1:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    bottom_cfg = bottom[phm_pkg::BOTTOM_W-1:0];
    scale_cfg = scale[phm_pkg::BOTTOM_W-1:0];
    decay_cfg = decay[phm_pkg::DECAY_W-1:0];
    master_cfg = master;
  endtask

  task automatic send_random_sample();
    int ch;
    int pk;
    int sel;
    int base;
    bit act;
    sel = $urandom_range(99);
    if ($urandom_range(99) < 6) ch = $urandom_range(15, NUM_METERS);
    else ch = $urandom_range(NUM_METERS - 1);
    act = ($urandom_range(99) < 85);
    base = (ch < NUM_METERS) ? int'(held_lvl[ch]) : 0;
    if (sel < 30)
      pk = 16 - int'($urandom_range(int'(bottom_cfg) + 48));
    else if (sel < 55)
      pk = base - int'($urandom_range(4 * int'(decay_cfg) + 8));
    else if (sel < 70)
      pk = int'($urandom_range(65535)) - 32768;
    else if (sel < 85)
      pk = int'(phm_pkg::LEVEL_FLOOR) + int'($urandom_range(200));
    else
      pk = int'($urandom_range(128)) - 64;
    if (pk < int'(phm_pkg::LEVEL_FLOOR)) pk = int'(phm_pkg::LEVEL_FLOOR);
    if (pk > 32767) pk = 32767;
    send_sample(ch, pk, act);
  endtask

  task automatic run_phase(input int n_msgs, input int send_pct, input int recv_pct);
    int target;
    target = msgs_predicted + n_msgs;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    while (msgs_predicted < target) send_random_sample();
    wait_idle();
  endtask

  task automatic test_reset_state();
    send_sample(0, 0, 1'b1);
    send_sample(0, -32768, 1'b1);
    send_sample(7, 32767, 1'b1);
    send_sample(1, -960, 1'b1);
    send_sample(2, -959, 1'b1);
    send_sample(3, -1, 1'b1);
    send_sample(4, 0, 1'b0);
    send_sample(8, 0, 1'b1);
    send_sample(9, 500, 1'b0);
    send_sample(10, 0, 1'b1);
    send_sample(15, -1, 1'b1);
    send_sample(5, -32768, 1'b1);
    wait_idle();
  endtask

  task automatic test_master_channels();
    set_config(960, 960, 8, 1'b1);
    send_sample(8, 100, 1'b0);
    send_sample(9, -500, 1'b1);
    send_sample(9, -32768, 1'b1);
    send_sample(6, -100, 1'b0);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    // zero floor depth with zero scale
    set_config(0, 0, 4095, 1'b1);
    send_sample(0, -1, 1'b1);
    send_sample(1, 0, 1'b1);
    wait_idle();
    // zero scale with deep floor, step clamps low
    set_config(16383, 0, 0, 1'b1);
    send_sample(2, -5, 1'b1);
    send_sample(4, -16382, 1'b1);
    wait_idle();
    // largest decay saturates at the floor
    set_config(16383, 16383, 4095, 1'b1);
    send_sample(6, -30000, 1'b1);
    send_sample(6, -32768, 1'b1);
    send_sample(1, 32767, 1'b1);
    send_sample(1, -32768, 1'b1);
    wait_idle();
    set_config(16383, 1, 4095, 1'b1);
    send_sample(3, -1, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    set_config(960, 960, 8, 1'b1);
    run_phase(210, 0, 0);
    set_config($urandom_range(3000, 16), $urandom_range(3000, 1), $urandom_range(100), 1'b1);
    run_phase(210, 61, 0);
    set_config(16383, 16383, 4095, 1'b1);
    run_phase(210, 0, 61);
    set_config($urandom_range(16383), $urandom_range(16383), $urandom_range(4095), 1'b1);
    run_phase(210, 7, 7);
    set_config(1, 1, 0, 1'($urandom_range(1)));
    run_phase(100, 0, 0);
  endtask

  task automatic test_backpressure();
    set_config(960, 480, 2, 1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_total = hold_total + HOLD_CYCLES;
    repeat (40) send_random_sample();
    wait_idle();
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= phm_pkg::REG_FLOOR_DEPTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.channel <= '0;
    in_ch.peak_db <= '0;
    in_ch.active <= 1'b0;
    bottom_cfg = phm_pkg::FLOOR_DEPTH_RST;
    scale_cfg = phm_pkg::SCALE_SPAN_RST;
    decay_cfg = phm_pkg::DECAY_STEP_RST;
    master_cfg = 1'b0;
    foreach (held_lvl[i]) held_lvl[i] = phm_pkg::LEVEL_FLOOR;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_master_channels();
    test_config_extremes();
    test_random_traffic();
    test_backpressure();
    wait_idle();

    $display("run covered %0d sample beats (%0d dropped), %0d messages checked, %0d errors",
             samples_sent, samples_dropped, msgs_checked, errors);
    $display("settings swept: reset, floor and scale extremes, random; idle, stall and hold-off");
    if (errors == 0) begin
      $display("** peak_hold_meter_led_driver: PASSED **");
    end else begin
      $display("** peak_hold_meter_led_driver: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
sv/phm_pkg.sv
sv/phm_if.sv
sv/phm_ctrl.sv
sv/phm_dp.sv
sv/peak_hold_meter_led_driver.sv
sv/phm_checker.sv
verif/tb_top.sv
